// File: sv/wppf_pkg.sv
package wppf_pkg;

  // Field widths
  localparam int SampleW = 14;
  localparam int IdxW    = 6;
  localparam int MeanW   = 18;
  localparam int SpreadW = 31;
  localparam int MinW    = 15;

  // Reset values of the record state and the threshold register
  localparam logic [SpreadW-1:0] SpreadMax = '1;
  localparam logic [MinW-1:0]    MinStart  = 15'd20000;
  localparam logic [SampleW-1:0] ThrReset  = 14'd100;

  typedef logic [SampleW-1:0] sample_t;

  // Per-item control that travels down the pipeline
  typedef struct packed {
    logic            win;
    logic            first;
    logic            last;
    logic [IdxW-1:0] start;
  } tag_t;

  // Record extremes snapshot taken on each sample, used on the last sample
  typedef struct packed {
    logic            pulse_found;
    sample_t         peak_value;
    logic [IdxW-1:0] peak_index;
    sample_t         floor_value;
    logic [IdxW-1:0] floor_index;
  } ext_t;

  typedef struct packed {
    logic               pulse_found;
    sample_t            peak_value;
    logic [IdxW-1:0]    peak_index;
    sample_t            floor_value;
    logic [IdxW-1:0]    floor_index;
    logic [IdxW-1:0]    baseline_start;
    logic [MeanW-1:0]   baseline_mean_q4;
    logic [SpreadW-1:0] baseline_spread;
  } result_t;

endpackage

// File: sv/wppf_sample_if.sv
interface wppf_sample_if;
  logic              valid;
  logic              ready;
  wppf_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/wppf_result_if.sv
interface wppf_result_if;
  logic              valid;
  logic              ready;
  wppf_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/wppf_extremes.sv
module wppf_extremes (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            last_i,
  input  wppf_pkg::sample_t               sample_i,
  input  logic [wppf_pkg::IdxW-1:0]       idx_i,
  input  wppf_pkg::sample_t               thr_i,
  output wppf_pkg::ext_t                  ext_o
);

  wppf_pkg::sample_t                run_max_q, max_d;
  logic [wppf_pkg::IdxW-1:0]        run_max_idx_q, max_idx_d;
  logic [wppf_pkg::MinW-1:0]        run_min_q, min_d;
  logic [wppf_pkg::IdxW-1:0]        run_min_idx_q, min_idx_d;
  wppf_pkg::ext_t                   ext_q, ext_d;

  // Update extremes, keep first occurrence on ties
  always_comb begin
    max_d     = run_max_q;
    max_idx_d = run_max_idx_q;
    min_d     = run_min_q;
    min_idx_d = run_min_idx_q;
    if (sample_i > run_max_q) begin
      max_d     = sample_i;
      max_idx_d = idx_i;
    end
    if (wppf_pkg::MinW'(sample_i) < run_min_q) begin
      min_d     = wppf_pkg::MinW'(sample_i);
      min_idx_d = idx_i;
    end
    ext_d.peak_value  = max_d;
    ext_d.peak_index  = max_idx_d;
    ext_d.floor_value = min_d[wppf_pkg::SampleW-1:0];
    ext_d.floor_index = min_idx_d;
    ext_d.pulse_found = (wppf_pkg::MinW'(max_d) >= min_d) &&
                        ((wppf_pkg::MinW'(max_d) - min_d) >= wppf_pkg::MinW'(thr_i));
  end

  // Hold running state, restart at record end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_max_q     <= '0;
      run_max_idx_q <= '0;
      run_min_q     <= wppf_pkg::MinStart;
      run_min_idx_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        run_max_q     <= '0;
        run_max_idx_q <= '0;
        run_min_q     <= wppf_pkg::MinStart;
        run_min_idx_q <= '0;
      end else begin
        run_max_q     <= max_d;
        run_max_idx_q <= max_idx_d;
        run_min_q     <= min_d;
        run_min_idx_q <= min_idx_d;
      end
    end
  end

  // Snapshot for the item moving down the pipeline
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      ext_q <= ext_d;
    end
  end

  assign ext_o = ext_q;

endmodule

// File: sv/wppf_window.sv
module wppf_window #(
  parameter int WINDOW_LEN = 7
) (
  input  logic                               clk_i,
  input  logic                               push_i,
  input  logic                               adv_i,
  input  wppf_pkg::sample_t                  sample_i,
  output logic [wppf_pkg::SpreadW-1:0]       spread_o,
  output logic [wppf_pkg::MeanW-1:0]         mean_o
);

  localparam int Lvl   = $clog2(WINDOW_LEN);
  localparam int P     = 1 << Lvl;
  localparam int SumW  = wppf_pkg::SampleW + Lvl;
  localparam int SqW   = 2 * wppf_pkg::SampleW + Lvl;
  localparam int XW    = SumW + 4;
  localparam int K     = XW + Lvl;
  localparam int RecW  = XW + 2;
  localparam int ProdW = XW + RecW;
  localparam int WideW = (SqW > wppf_pkg::SpreadW) ? SqW : wppf_pkg::SpreadW;
  localparam longint unsigned RecipL =
    ((longint'(1) << K) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
  localparam logic [RecW-1:0] Recip = RecW'(RecipL);

  wppf_pkg::sample_t            tap_q [WINDOW_LEN];
  wppf_pkg::sample_t            s1_tap_q [WINDOW_LEN];
  wppf_pkg::sample_t            s1_max_q;
  logic [SumW-1:0]              s1_sum_q;
  logic [2*wppf_pkg::SampleW-1:0] s2_sq_q [WINDOW_LEN];
  logic [ProdW-1:0]             s2_prod_q;
  logic [SqW-1:0]               s3_sq_sum_q;
  logic [wppf_pkg::MeanW-1:0]   s3_mean_q;
  logic [wppf_pkg::SpreadW-1:0] spread_q;
  logic [wppf_pkg::MeanW-1:0]   mean_q;

  wppf_pkg::sample_t            mx [Lvl+1][P];
  logic [SumW-1:0]              sm [Lvl+1][P];
  logic [SqW-1:0]               sq [Lvl+1][P];
  wppf_pkg::sample_t            diff [WINDOW_LEN];
  logic [WideW-1:0]             sq_wide;

  // Shift line of the newest samples
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        tap_q[i] <= tap_q[i+1];
      end
      tap_q[WINDOW_LEN-1] <= sample_i;
    end
  end

  // Window maximum and sum trees
  always_comb begin
    for (int l = 0; l <= Lvl; l++) begin
      for (int i = 0; i < P; i++) begin
        mx[l][i] = '0;
        sm[l][i] = '0;
      end
    end
    for (int i = 0; i < WINDOW_LEN; i++) begin
      mx[0][i] = tap_q[i];
      sm[0][i] = SumW'(tap_q[i]);
    end
    for (int l = 0; l < Lvl; l++) begin
      for (int i = 0; i < (P >> (l + 1)); i++) begin
        mx[l+1][i] = (mx[l][2*i] > mx[l][2*i+1]) ? mx[l][2*i] : mx[l][2*i+1];
        sm[l+1][i] = sm[l][2*i] + sm[l][2*i+1];
      end
    end
  end

  // Differences from window maximum
  always_comb begin
    for (int i = 0; i < WINDOW_LEN; i++) begin
      diff[i] = s1_max_q - s1_tap_q[i];
    end
  end

  // Sum of squares tree
  always_comb begin
    for (int l = 0; l <= Lvl; l++) begin
      for (int i = 0; i < P; i++) begin
        sq[l][i] = '0;
      end
    end
    for (int i = 0; i < WINDOW_LEN; i++) begin
      sq[0][i] = SqW'(s2_sq_q[i]);
    end
    for (int l = 0; l < Lvl; l++) begin
      for (int i = 0; i < (P >> (l + 1)); i++) begin
        sq[l+1][i] = sq[l][2*i] + sq[l][2*i+1];
      end
    end
  end

  assign sq_wide = WideW'(s3_sq_sum_q);

  // Advance the window pipeline
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_max_q <= mx[Lvl][0];
      s1_sum_q <= sm[Lvl][0];
      for (int i = 0; i < WINDOW_LEN; i++) begin
        s1_tap_q[i] <= tap_q[i];
        s2_sq_q[i]  <= (2*wppf_pkg::SampleW)'(diff[i]) * (2*wppf_pkg::SampleW)'(diff[i]);
      end
      // mean = sum*16/WINDOW_LEN by reciprocal multiply
      s2_prod_q   <= ProdW'({s1_sum_q, 4'b0000}) * ProdW'(Recip);
      s3_sq_sum_q <= sq[Lvl][0];
      s3_mean_q   <= wppf_pkg::MeanW'(s2_prod_q >> K);
      spread_q    <= (sq_wide > WideW'(wppf_pkg::SpreadMax)) ? wppf_pkg::SpreadMax
                                                               : sq_wide[wppf_pkg::SpreadW-1:0];
      mean_q      <= s3_mean_q;
    end
  end

  assign spread_o = spread_q;
  assign mean_o   = mean_q;

endmodule

// File: sv/wppf_select.sv
module wppf_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  wppf_pkg::tag_t                tag_i,
  input  logic [wppf_pkg::SpreadW-1:0]  spread_i,
  input  logic [wppf_pkg::MeanW-1:0]    mean_i,
  input  wppf_pkg::ext_t                ext_i,
  output logic                          adv_o,
  wppf_result_if.source                 result_o
);

  logic                         out_valid_q;
  wppf_pkg::result_t            out_q, out_d;
  logic [wppf_pkg::SpreadW-1:0] best_spread_q, best_spread_d;
  logic [wppf_pkg::MeanW-1:0]   best_mean_q, best_mean_d;
  logic [wppf_pkg::IdxW-1:0]    best_start_q, best_start_d;
  logic                         take;
  logic                         emit;

  // Stall only when a new result meets one that still waits
  assign emit  = s_valid_i && tag_i.last;
  assign adv_o = !out_valid_q || result_o.ready || !emit;

  // Keep the flattest window, earlier wins on a tie
  always_comb begin
    take = s_valid_i && tag_i.win && (tag_i.first || (spread_i < best_spread_q));
    best_spread_d = take ? spread_i    : best_spread_q;
    best_mean_d   = take ? mean_i      : best_mean_q;
    best_start_d  = take ? tag_i.start : best_start_q;

    out_d.pulse_found      = ext_i.pulse_found;
    out_d.peak_value       = ext_i.peak_value;
    out_d.peak_index       = ext_i.peak_index;
    out_d.floor_value      = ext_i.floor_value;
    out_d.floor_index      = ext_i.floor_index;
    out_d.baseline_start   = best_start_d;
    out_d.baseline_mean_q4 = best_mean_d;
    out_d.baseline_spread  = best_spread_d;
  end

  // Hold best window and the result register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      best_spread_q <= wppf_pkg::SpreadMax;
      best_mean_q   <= '0;
      best_start_q  <= '0;
    end else if (adv_o) begin
      out_valid_q <= emit || (out_valid_q && !result_o.ready);
      if (emit) begin
        best_spread_q <= wppf_pkg::SpreadMax;
        best_mean_q   <= '0;
        best_start_q  <= '0;
      end else begin
        best_spread_q <= best_spread_d;
        best_mean_q   <= best_mean_d;
        best_start_q  <= best_start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && emit) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

// File: sv/waveform_peak_and_pedestal_finder_top.sv
// Channel     Dir  Handshake      Payload
// sample_i    in   valid/ready    sample (14 b)
// result_o    out  valid/ready    pulse, peak, floor, baseline start/mean/spread
// cfg_we_i    in   write enable   cfg_wdata_i -> amplitude_threshold (14 b)
//
// One sample per cycle is taken while ready is high; each sample passes a five-register
// pipeline (input, window max/sum, squares, square sum, saturation) and the record
// result lands in the output register after the last sample leaves the saturation
// stage. Reset clears the record state and sets the threshold to 100.
// A waiting result stops the pipeline and drops ready only while the next
// record's result is at the last stage.
module waveform_peak_and_pedestal_finder_top #(
  parameter int RECORD_LEN = 48,
  parameter int WINDOW_LEN = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  wppf_pkg::sample_t   cfg_wdata_i,
  wppf_sample_if.sink         sample_i,
  wppf_result_if.source       result_o
);

  localparam int CntW = $clog2(RECORD_LEN);

  logic                         adv;
  logic                         accept;
  logic [CntW-1:0]              cnt_q;
  wppf_pkg::sample_t            thr_q;
  logic                         s0_valid_q;
  wppf_pkg::sample_t            s0_sample_q;
  logic [wppf_pkg::IdxW-1:0]    s0_idx_q;
  wppf_pkg::tag_t               s0_tag_q, s0_tag_d;
  logic                         vld_q [1:4];
  wppf_pkg::tag_t               tag_q [1:4];
  wppf_pkg::ext_t               ext_s1, ext_s2_q, ext_s3_q, ext_s4_q;
  logic [wppf_pkg::SpreadW-1:0] spread;
  logic [wppf_pkg::MeanW-1:0]   mean;

  assign sample_i.ready = adv;
  assign accept         = sample_i.valid && adv;

  // Tag the incoming sample by its place in the record
  always_comb begin
    s0_tag_d.last  = (cnt_q == CntW'(RECORD_LEN - 1));
    s0_tag_d.win   = (32'(cnt_q) >= 32'(WINDOW_LEN - 1));
    s0_tag_d.first = (32'(cnt_q) == 32'(WINDOW_LEN - 1));
    s0_tag_d.start = wppf_pkg::IdxW'(32'(cnt_q) - 32'(WINDOW_LEN - 1));
  end

  // Threshold register, sample counter and control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= wppf_pkg::ThrReset;
      cnt_q      <= '0;
      s0_valid_q <= 1'b0;
      for (int i = 1; i <= 4; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept) begin
        cnt_q <= s0_tag_d.last ? '0 : cnt_q + CntW'(1);
      end
      if (adv) begin
        s0_valid_q <= accept;
        vld_q[1]   <= s0_valid_q;
        for (int i = 2; i <= 4; i++) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Payload side of the pipeline
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_sample_q <= sample_i.data;
      s0_idx_q    <= wppf_pkg::IdxW'(cnt_q);
      s0_tag_q    <= s0_tag_d;
    end
    if (adv) begin
      tag_q[1] <= s0_tag_q;
      for (int i = 2; i <= 4; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      ext_s2_q <= ext_s1;
      ext_s3_q <= ext_s2_q;
      ext_s4_q <= ext_s3_q;
    end
  end

  wppf_extremes u_extremes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv && s0_valid_q),
    .last_i   (s0_tag_q.last),
    .sample_i (s0_sample_q),
    .idx_i    (s0_idx_q),
    .thr_i    (thr_q),
    .ext_o    (ext_s1)
  );

  wppf_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i    (clk_i),
    .push_i   (accept),
    .adv_i    (adv),
    .sample_i (sample_i.data),
    .spread_o (spread),
    .mean_o   (mean)
  );

  wppf_select u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (vld_q[4]),
    .tag_i     (tag_q[4]),
    .spread_i  (spread),
    .mean_i    (mean),
    .ext_i     (ext_s4_q),
    .adv_o     (adv),
    .result_o  (result_o)
  );

  // A result appears only after a record's last sample leaves the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(vld_q[4] && tag_q[4].last))
    else $error("result without a last sample");

  // Counter restarts after the last sample of a record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s0_tag_d.last) |=> (cnt_q == '0))
    else $error("sample counter did not restart");

  // The first window of a record starts at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4] && tag_q[4].first) |-> (tag_q[4].win && (tag_q[4].start == '0)))
    else $error("first window misplaced");

  // A new result blocked by a waiting one freezes the last pipeline stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready && vld_q[4] && tag_q[4].last)
      |=> ($stable(vld_q[4]) && $stable(tag_q[4])))
    else $error("pipeline moved during stall");

endmodule
